FILE: rtl/core/prle_pkg.sv
// prle_pkg: shared types, constants and run coding for the palette run-length encoder
`timescale 1ns / 1ps
`default_nettype none
package prle_pkg;

	localparam int DefaultMaxRun = 255;
	localparam int MaxBytes      = 4;
	localparam int CountW        = 3;
	localparam int ByteIdxW      = 2;
	localparam logic [7:0] ShortLenMax = 8'd15;
	localparam int NibbleShift   = 4;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic       row_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} out_item_t;

	// bytes caused by one pixel, byte 0 goes out first
	typedef struct packed {
		logic                          valid;
		logic [CountW-1:0]             count;
		logic [MaxBytes-1:0][7:0]      bytes;
	} byte_bundle_t;

	typedef struct packed {
		logic            two;
		logic [1:0][7:0] b;
	} run_code_t;

	// one byte (len:idx nibbles) or two bytes (idx, len)
	function automatic run_code_t run_code(input logic [7:0] value, input logic [7:0] len,
			input logic small_mode);
		run_code_t rc;
		rc = '0;
		if (small_mode && (len <= ShortLenMax) && (value <= ShortLenMax)) begin
			rc.two  = 1'b0;
			rc.b[0] = value | 8'(len << NibbleShift);
			rc.b[1] = 8'd0;
		end else begin
			rc.two  = 1'b1;
			rc.b[0] = value;
			rc.b[1] = len;
		end
		return rc;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/palette_run_length_encoder_unit.sv
// palette_run_length_encoder_unit: top level of the palette run-length encoder
// palette indices come in one pixel per transaction with a row-end flag; runs of equal
// indices inside a row close on an index change, at MAX_RUN pixels, or at row end, and
// each closed run goes out as index then length, or as one byte (length high nibble,
// index low nibble) when small_palette is set and both fit in a nibble. the run state and
// the up-to-four result bytes of a pixel are formed in a single registered pass, so a new
// pixel can enter every cycle while the byte serializer keeps up. the output carries one
// byte per transaction, so a pixel that causes n bytes holds the output for n transactions;
// the sustained pixel rate is set by that one-byte output port. one bundle register plus
// the serializer's own hold register let the next pixel be taken while a finished byte is
// still waiting. last_byte marks the final byte caused by a pixel. the user must write
// small_palette through cfg_wr_en/cfg_wr_data only while idle; the unit does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module palette_run_length_encoder_unit #(
	parameter int MAX_RUN = prle_pkg::DefaultMaxRun
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire prle_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output prle_pkg::out_item_t      out_data
);

	// configuration register
	logic small_palette_q;

	// handshake between the stages
	logic                   in_accept;
	logic                   take;
	prle_pkg::byte_bundle_t bundle_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_palette_q <= 1'b0;
		end else if (cfg_wr_en) begin
			small_palette_q <= cfg_wr_data;
		end
	end

	// bundle register is free when empty or being moved into the serializer this cycle
	assign in_stall  = bundle_s1.valid && !take;
	assign in_accept = in_valid && !in_stall;

	prle_encoder #(
		.MAX_RUN(MAX_RUN)
	) u_encoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.small_palette(small_palette_q),
		.accept       (in_accept),
		.item         (in_data),
		.take         (take),
		.bundle_s1    (bundle_s1)
	);

	prle_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.bundle_s1(bundle_s1),
		.take     (take),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// a byte that is not the last of its pixel is always followed by another
	a_more_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_byte |=> out_valid)
		else $error("byte sequence cut short");

	// input stalls only while both the bundle register and the serializer are busy
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (bundle_s1.valid && out_valid))
		else $error("input stalled with a free stage");

	// a waiting bundle moves into an idle serializer at once
	a_bundle_moves: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_s1.valid && !out_valid |=> out_valid)
		else $error("bundle not moved to idle serializer");

	// a held bundle never claims more bytes than one pixel can cause
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bundle_s1.valid |-> (bundle_s1.count != 3'd0 && bundle_s1.count <= 3'd4))
		else $error("bundle byte count out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/prle_encoder.sv
// prle_encoder: run state and per-pixel byte bundle register
`timescale 1ns / 1ps
`default_nettype none
module prle_encoder #(
	parameter int MAX_RUN = prle_pkg::DefaultMaxRun
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               small_palette,
	input  wire logic               accept,
	input  wire prle_pkg::in_item_t item,
	input  wire logic               take,
	output prle_pkg::byte_bundle_t  bundle_s1
);

	localparam logic [7:0] MaxRunW = 8'(MAX_RUN);

	logic       run_open_q;
	logic [7:0] run_value_q;
	logic [7:0] run_length_q;

	logic                      emit_a;
	logic [7:0]                new_value;
	logic [7:0]                new_len;
	prle_pkg::run_code_t       code_a;
	prle_pkg::run_code_t       code_b;
	logic [prle_pkg::CountW-1:0] na;
	logic [prle_pkg::CountW-1:0] nb;
	prle_pkg::byte_bundle_t    bundle_d;

	always_comb begin
		emit_a = run_open_q &&
			((item.pixel_index != run_value_q) || (run_length_q >= MaxRunW));
		if (!run_open_q || emit_a) begin
			new_value = item.pixel_index;
			new_len   = 8'd1;
		end else begin
			new_value = run_value_q;
			new_len   = run_length_q + 8'd1;
		end
		code_a = prle_pkg::run_code(run_value_q, run_length_q, small_palette);
		code_b = prle_pkg::run_code(new_value, new_len, small_palette);
		na = emit_a ? (code_a.two ? 3'd2 : 3'd1) : 3'd0;
		nb = item.row_end ? (code_b.two ? 3'd2 : 3'd1) : 3'd0;

		bundle_d = '0;
		bundle_d.bytes[0] = code_a.b[0];
		bundle_d.bytes[1] = code_a.b[1];
		case (na)
			3'd0: begin
				bundle_d.bytes[0] = code_b.b[0];
				bundle_d.bytes[1] = code_b.b[1];
			end
			3'd1: begin
				bundle_d.bytes[1] = code_b.b[0];
				bundle_d.bytes[2] = code_b.b[1];
			end
			default: begin
				bundle_d.bytes[2] = code_b.b[0];
				bundle_d.bytes[3] = code_b.b[1];
			end
		endcase
		bundle_d.count = na + nb;
		bundle_d.valid = (bundle_d.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q   <= 1'b0;
			run_value_q  <= 8'd0;
			run_length_q <= 8'd0;
			bundle_s1    <= '0;
		end else begin
			if (accept) begin
				if (item.row_end) begin
					run_open_q   <= 1'b0;
					run_value_q  <= 8'd0;
					run_length_q <= 8'd0;
				end else begin
					run_open_q   <= 1'b1;
					run_value_q  <= new_value;
					run_length_q <= new_len;
				end
				bundle_s1 <= bundle_d;
			end else if (take) begin
				bundle_s1.valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/prle_serializer.sv
// prle_serializer: sends a byte bundle out one byte per transaction
`timescale 1ns / 1ps
`default_nettype none
module prle_serializer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire prle_pkg::byte_bundle_t bundle_s1,
	output logic                        take,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output prle_pkg::out_item_t         out_data
);

	prle_pkg::byte_bundle_t          hold_q;
	logic [prle_pkg::ByteIdxW-1:0]   idx_q;
	logic                            at_last;
	logic                            fire;

	always_comb begin
		out_valid = hold_q.valid;
		at_last   = ({1'b0, idx_q} + 3'd1) == hold_q.count;
		fire      = hold_q.valid && !out_stall;
		take      = bundle_s1.valid && (!hold_q.valid || (fire && at_last));
		out_data.code_byte = hold_q.bytes[idx_q];
		out_data.last_byte = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			idx_q  <= '0;
		end else begin
			if (take) begin
				hold_q <= bundle_s1;
				idx_q  <= '0;
			end else if (fire) begin
				if (at_last) begin
					hold_q.valid <= 1'b0;
					idx_q        <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb_palette_run_length_encoder_unit.sv
// tb_palette_run_length_encoder_unit: self-checking testbench for the palette run-length encoder
`timescale 1ns / 1ps
module tb_palette_run_length_encoder_unit;

	// the unit runs at its default run limit; the predictor uses the same value
	localparam int RUN_LIMIT   = prle_pkg::DefaultMaxRun;
	localparam int NIBBLE_MAX  = 15;
	// cycles with no transaction on either side before the run is given up
	localparam int QUIET_LIMIT = 4000;
	// cycles allowed after the last expected byte for a pixel with no bytes to settle
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int PRINT_CAP     = 100;

	typedef enum logic {
		STEP_PIXEL,
		STEP_CONFIG
	} step_kind_t;

	// one directed table row; a config row carries the mode bit in pixel[0]
	typedef struct packed {
		step_kind_t      kind;
		logic [7:0]      pixel;
		logic            row_end;
		logic            typed;
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
	} table_step_t;

	// per accepted pixel: either typed-in bytes or a request to use the predictor
	typedef struct packed {
		logic                          typed;
		logic [2:0]                    count;
		prle_pkg::out_item_t [3:0]     bytes;
	} pixel_expect_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic                cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	prle_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	prle_pkg::out_item_t out_data;

	palette_run_length_encoder_unit #(
		.MAX_RUN(RUN_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// predictor state: its own copy of the mode register and the open run
	logic                palette_small;
	logic                run_open;
	logic [7:0]          run_idx;
	logic [7:0]          run_len;
	prle_pkg::out_item_t pixel_bytes [4];
	int                  pixel_count;

	// bytes still owed by the unit, oldest first
	prle_pkg::out_item_t expected_bytes [$];
	// one entry per pixel handed to the driver, popped when the unit takes it
	pixel_expect_t       pixel_notes [$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int items_sent     = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;

	pixel_expect_t       seen_note;
	prle_pkg::out_item_t want_byte;
	int                  mon_k;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void add_code_byte(input logic [7:0] b);
		pixel_bytes[pixel_count].code_byte = b;
		pixel_bytes[pixel_count].last_byte = 1'b0;
		pixel_count++;
	endfunction

	// short run with a nibble-sized index packs as {length, index}, else index then length
	function automatic void emit_run_code();
		if (palette_small && run_len <= NIBBLE_MAX && run_idx <= NIBBLE_MAX) begin
			add_code_byte({run_len[3:0], run_idx[3:0]});
		end else begin
			add_code_byte(run_idx);
			add_code_byte(run_len);
		end
	endfunction

	// bytes caused by one pixel land in pixel_bytes[0 .. pixel_count-1]
	function automatic void encode_pixel(input prle_pkg::in_item_t px);
		pixel_count = 0;
		if (!run_open) begin
			// first pixel of a row opens a run
			run_open = 1'b1;
			run_idx  = px.pixel_index;
			run_len  = 8'd1;
		end else if (px.pixel_index != run_idx || run_len >= RUN_LIMIT) begin
			// index change, or the run already sits at its limit
			emit_run_code();
			run_idx = px.pixel_index;
			run_len = 8'd1;
		end else begin
			run_len = run_len + 8'd1;
		end
		if (px.row_end) begin
			emit_run_code();
			run_open = 1'b0;
			run_idx  = 8'd0;
			run_len  = 8'd0;
		end
		if (pixel_count > 0)
			pixel_bytes[pixel_count - 1].last_byte = 1'b1;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// monitor: input transactions feed the predictor, output transactions
	// are checked against the oldest expected byte; values are read at the
	// edge before any update lands, so the order of processes does not matter
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			seen_note = '0;
			if (pixel_notes.size() != 0)
				seen_note = pixel_notes.pop_front();
			encode_pixel(in_data);
			if (seen_note.typed) begin
				for (mon_k = 0; mon_k < seen_note.count; mon_k++)
					expected_bytes.push_back(seen_note.bytes[mon_k]);
			end else begin
				for (mon_k = 0; mon_k < pixel_count; mon_k++)
					expected_bytes.push_back(pixel_bytes[mon_k]);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				flag_mismatch($sformatf("byte %02h with nothing expected", out_data.code_byte));
			end else begin
				want_byte = expected_bytes.pop_front();
				if (out_data.code_byte !== want_byte.code_byte)
					flag_mismatch($sformatf("code_byte %02h, expected %02h",
						out_data.code_byte, want_byte.code_byte));
				if (out_data.last_byte !== want_byte.last_byte)
					flag_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
						out_data.last_byte, want_byte.last_byte, want_byte.code_byte));
			end
		end
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_palette_run_length_encoder_unit: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------

	// optional idle cycles, then hold the pixel until the unit takes it
	task automatic send_pixel(input logic [7:0] pix, input logic re, input pixel_expect_t note);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_notes.push_back(note);
		in_valid <= 1'b1;
		in_data  <= '{pixel_index: pix, row_end: re};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// drop valid and wait until every owed byte has come out
	task automatic drain_output(input int settle);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// mode register is only touched with the unit idle and no run open
	task automatic set_palette_mode(input logic mode);
		drain_output(SETTLE_CYCLES);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		palette_small = mode;
	endtask

	task automatic send_run(input logic [7:0] pix, input int len, input logic end_row);
		int i;
		for (i = 0; i < len; i++)
			send_pixel(pix, end_row && (i == len - 1), '0);
	endtask

	// mostly well-formed rows of runs near the nibble boundary, some noise rows
	task automatic random_row();
		int pick;
		int nruns;
		int r;
		int len;
		int i;
		logic [7:0] pix;
		pick = $urandom_range(99);
		if (pick < 75) begin
			nruns = $urandom_range(1, 6);
			for (r = 0; r < nruns; r++) begin
				if ($urandom_range(3) != 0)
					pix = 8'($urandom_range(0, NIBBLE_MAX));
				else
					pix = 8'($urandom_range(0, 255));
				pick = $urandom_range(99);
				if (pick < 40)
					len = $urandom_range(1, 3);
				else if (pick < 80)
					len = $urandom_range(NIBBLE_MAX - 2, NIBBLE_MAX + 2);
				else
					len = $urandom_range(4, 12);
				send_run(pix, len, r == nruns - 1);
			end
		end else begin
			// noise: random indices, row ends anywhere
			len = $urandom_range(1, 8);
			for (i = 0; i < len; i++)
				send_pixel(8'($urandom_range(0, 255)),
					(i == len - 1) || ($urandom_range(9) == 0), '0);
		end
	endtask

	task automatic run_phase(input logic mode, input int send_pct, input int recv_pct,
			input logic long_row);
		int start;
		set_palette_mode(mode);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
		// one run at or just past the limit, ended by the row mark
		if (long_row)
			send_run(8'($urandom_range(0, 255)), $urandom_range(RUN_LIMIT, RUN_LIMIT + 20),
				1'b1);
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS)
			random_row();
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------

	table_step_t steps [$];

	function automatic void add_step(input step_kind_t kind, input logic [7:0] pix,
			input logic re, input logic typed, input int count,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3);
		table_step_t s;
		s.kind    = kind;
		s.pixel   = pix;
		s.row_end = re;
		s.typed   = typed;
		s.count   = count[2:0];
		s.bytes   = {b3, b2, b1, b0};
		steps.push_back(s);
	endfunction

	task automatic run_directed();
		pixel_expect_t note;
		int i;
		int k;
		// two-byte mode straight out of reset
		// lone pixel that is also the row end, lowest index
		add_step(STEP_PIXEL, 8'h00, 1'b1, 1'b1, 2, 8'h00, 8'h01, 8'h00, 8'h00);
		// highest index, quiet pixels while the run grows
		add_step(STEP_PIXEL, 8'hff, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'hff, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		// index change together with row end: old run plus a one-pixel run
		add_step(STEP_PIXEL, 8'h00, 1'b1, 1'b1, 4, 8'hff, 8'h02, 8'h00, 8'h01);
		add_step(STEP_PIXEL, 8'h07, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h07, 1'b1, 1'b1, 2, 8'h07, 8'h02, 8'h00, 8'h00);
		// one-byte runs allowed from here
		add_step(STEP_CONFIG, 8'h01, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h05, 1'b1, 1'b1, 1, 8'h15, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h0f, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h0f, 1'b1, 1'b1, 1, 8'h2f, 8'h00, 8'h00, 8'h00);
		// index too wide for a nibble keeps the two-byte form
		add_step(STEP_PIXEL, 8'h10, 1'b1, 1'b1, 2, 8'h10, 8'h01, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h03, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'hc8, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'hc8, 1'b1, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		// change and row end, both runs short
		add_step(STEP_PIXEL, 8'h09, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h0a, 1'b1, 1'b1, 2, 8'h19, 8'h1a, 8'h00, 8'h00);
		// alternating bit patterns
		add_step(STEP_PIXEL, 8'haa, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h55, 1'b1, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		// back to two-byte mode
		add_step(STEP_CONFIG, 8'h00, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h00, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h01, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		add_step(STEP_PIXEL, 8'h01, 1'b1, 1'b0, 0, 8'h00, 8'h00, 8'h00, 8'h00);

		for (i = 0; i < steps.size(); i++) begin
			if (steps[i].kind == STEP_CONFIG) begin
				set_palette_mode(steps[i].pixel[0]);
			end else begin
				note       = '0;
				note.typed = steps[i].typed;
				note.count = steps[i].count;
				for (k = 0; k < steps[i].count; k++) begin
					note.bytes[k].code_byte = steps[i].bytes[k];
					note.bytes[k].last_byte = (k == steps[i].count - 1);
				end
				send_pixel(steps[i].pixel, steps[i].row_end, note);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence: reset, directed table, three random phases with the
	// idling swapped between sides and then switched off, final drain
	// ------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		palette_small = 1'b0;
		run_open      = 1'b0;
		run_idx       = 8'd0;
		run_len       = 8'd0;
		pixel_count   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 38;
		stall_pct     = 78;
		run_directed();

		run_phase(1'b1, 38, 78, 1'b1);
		run_phase(1'b0, 78, 38, 1'b0);
		run_phase(1'b1, 0, 0, 1'b0);

		// every byte in, then a few cycles to catch any stray transaction
		drain_output(4 * SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("tb_palette_run_length_encoder_unit: clean");
		else
			$display("tb_palette_run_length_encoder_unit: errors");
		$finish;
	end

endmodule
